@@ rtl/bpd_pkg.sv @@
// shared types and constants of the short/long press detector
package bpd_pkg;

    localparam int FIELD_W          = 2;
    localparam int TICK_W           = 8;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_ADDR_W       = 3;
    localparam int NUM_BUTTONS_DEF  = 2;

    localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 8'd5;
    localparam logic [TICK_W-1:0] LONG_RESET     = 8'd100;

    localparam logic REG_DEBOUNCE_SCANS = 1'b0;
    localparam logic REG_LONG_SCANS     = 1'b1;

    localparam logic KIND_SCAN = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic scan;
        logic pressed;
        logic clr_short;
        logic clr_long;
    } bpd_cmd_t;

endpackage

@@ rtl/button_short_long_press_detector_unit.sv @@
// top level of the button short/long press detector
//
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_kind, s_pin_levels, s_read_short_mask, s_read_long_mask
// m_        out        m_valid / m_ready  m_short_flags, m_long_flags
// apb       in         psel / penable     paddr, pwdata, pwrite, prdata, pready
//
// one word in, one word out, one word per cycle sustained while m_ready stays high
// the result is registered and appears in the cycle after the input word is taken
// the output register holds the result while m_ready is low; s_ready follows it
// aresetn is synchronous and active low; registers return to 5 and 100
module button_short_long_press_detector_unit
    import bpd_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  logic [FIELD_W-1:0]    s_pin_levels,
    input  logic [FIELD_W-1:0]    s_read_short_mask,
    input  logic [FIELD_W-1:0]    s_read_long_mask,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [FIELD_W-1:0]    m_short_flags,
    output logic [FIELD_W-1:0]    m_long_flags,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [TICK_W-1:0]      debounce_scans_reg;
    logic [TICK_W-1:0]      long_scans_reg;
    logic                   started_reg;
    logic                   m_valid_reg;
    logic [FIELD_W-1:0]     m_short_flags_reg, m_short_flags_next;
    logic [FIELD_W-1:0]     m_long_flags_reg, m_long_flags_next;
    logic                   in_accept;
    logic                   cfg_write;
    logic                   reg_sel;
    logic [NUM_BUTTONS-1:0] short_now, long_now, short_nxt, long_nxt;
    logic [FIELD_W-1:0]     short_field_now, long_field_now;
    logic [FIELD_W-1:0]     short_field_nxt, long_field_nxt;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = {{(CFG_DATA_W-TICK_W){1'b0}},
                        (reg_sel == REG_LONG_SCANS) ? long_scans_reg : debounce_scans_reg};

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
        bpd_cmd_t cmd;
        if (i < FIELD_W) begin : g_pin
            assign cmd.pressed   = !s_pin_levels[i];
            assign cmd.clr_short = in_accept && (s_kind == KIND_READ) && s_read_short_mask[i];
            assign cmd.clr_long  = in_accept && (s_kind == KIND_READ) && s_read_long_mask[i];
        end else begin : g_nopin
            assign cmd.pressed   = 1'b1;
            assign cmd.clr_short = 1'b0;
            assign cmd.clr_long  = 1'b0;
        end
        assign cmd.scan = in_accept && (s_kind == KIND_SCAN) && started_reg;

        bpd_button u_button (
            .aclk            (aclk),
            .aresetn         (aresetn),
            .cmd             (cmd),
            .debounce_scans  (debounce_scans_reg),
            .long_scans      (long_scans_reg),
            .short_flag      (short_now[i]),
            .long_flag       (long_now[i]),
            .short_flag_next (short_nxt[i]),
            .long_flag_next  (long_nxt[i])
        );
    end

    for (genvar j = 0; j < FIELD_W; j++) begin : g_field
        if (j < NUM_BUTTONS) begin : g_used
            assign short_field_now[j] = short_now[j];
            assign long_field_now[j]  = long_now[j];
            assign short_field_nxt[j] = short_nxt[j];
            assign long_field_nxt[j]  = long_nxt[j];
        end else begin : g_unused
            assign short_field_now[j] = 1'b0;
            assign long_field_now[j]  = 1'b0;
            assign short_field_nxt[j] = 1'b0;
            assign long_field_nxt[j]  = 1'b0;
        end
    end

    always_comb begin
        unique case (s_kind)
            KIND_SCAN: begin
                m_short_flags_next = short_field_nxt;
                m_long_flags_next  = long_field_nxt;
            end
            KIND_READ: begin
                m_short_flags_next = short_field_now & s_read_short_mask;
                m_long_flags_next  = long_field_now & s_read_long_mask;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_scans_reg <= DEBOUNCE_RESET;
            long_scans_reg     <= LONG_RESET;
            started_reg        <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (reg_sel)
                    REG_DEBOUNCE_SCANS: debounce_scans_reg <= pwdata[TICK_W-1:0];
                    REG_LONG_SCANS:     long_scans_reg     <= pwdata[TICK_W-1:0];
                endcase
            end
            if (in_accept && (s_kind == KIND_SCAN)) begin
                started_reg <= 1'b1;
            end
            if (in_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_short_flags_reg <= m_short_flags_next;
            m_long_flags_reg  <= m_long_flags_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_short_flags = m_short_flags_reg;
    assign m_long_flags  = m_long_flags_reg;

`ifndef SYNTHESIS
    a_read_clears_short: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && (s_kind == KIND_READ) && s_read_short_mask[0] |=> !short_now[0])
        else $error("short flag not cleared by read");

    a_read_clears_long: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && (s_kind == KIND_READ) && s_read_long_mask[0] |=> !long_now[0])
        else $error("long flag not cleared by read");

    a_result_from_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(in_accept))
        else $error("result appeared without an accepted word");

    a_started_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(started_reg))
        else $error("started dropped outside reset");
`endif

endmodule

@@ rtl/bpd_button.sv @@
// per-button debounce and short/long press state machine
module bpd_button
    import bpd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  bpd_cmd_t          cmd,
    input  logic [TICK_W-1:0] debounce_scans,
    input  logic [TICK_W-1:0] long_scans,
    output logic              short_flag,
    output logic              long_flag,
    output logic              short_flag_next,
    output logic              long_flag_next
);

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_SHORT    = 2'd2,
        PH_LONG     = 2'd3
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic              short_reg, long_reg;
    logic [TICK_W-1:0] ticks_inc;
    logic [TICK_W-1:0] limit;
    logic              expired;

    assign ticks_inc = (ticks_reg == {TICK_W{1'b1}}) ? ticks_reg : ticks_reg + 1'b1;
    assign limit     = (phase_reg == PH_SHORT) ? long_scans : debounce_scans;
    assign expired   = (ticks_inc >= limit);

    always_comb begin
        phase_next      = phase_reg;
        ticks_next      = ticks_reg;
        short_flag_next = short_reg;
        long_flag_next  = long_reg;
        if (cmd.scan) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (cmd.pressed) begin
                        ticks_next = '0;
                        phase_next = PH_DEBOUNCE;
                    end
                end
                PH_DEBOUNCE: begin
                    if (!cmd.pressed) begin
                        phase_next = PH_IDLE;
                    end else begin
                        ticks_next = expired ? '0 : ticks_inc;
                        if (expired) begin
                            phase_next = PH_SHORT;
                        end
                    end
                end
                PH_SHORT: begin
                    if (!cmd.pressed) begin
                        short_flag_next = 1'b1;
                        phase_next      = PH_IDLE;
                    end else begin
                        ticks_next = expired ? '0 : ticks_inc;
                        if (expired) begin
                            phase_next     = PH_LONG;
                            long_flag_next = 1'b1;
                        end
                    end
                end
                PH_LONG: begin
                    if (!cmd.pressed) begin
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end else begin
            if (cmd.clr_short) begin
                short_flag_next = 1'b0;
            end
            if (cmd.clr_long) begin
                long_flag_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            ticks_reg <= '0;
            short_reg <= 1'b0;
            long_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
            short_reg <= short_flag_next;
            long_reg  <= long_flag_next;
        end
    end

    assign short_flag = short_reg;
    assign long_flag  = long_reg;

endmodule

@@ tb/sv/button_short_long_press_detector_unit_tb.sv @@
// self-checking testbench for the button short/long press detector
module button_short_long_press_detector_unit_tb
    import bpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BTN        = NUM_BUTTONS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef enum logic [1:0] {PH_IDLE, PH_DEBOUNCE, PH_SHORT, PH_LONG} btn_phase_t;

    typedef struct packed {
        logic [FIELD_W-1:0] short_f;
        logic [FIELD_W-1:0] long_f;
    } flags_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_kind = KIND_SCAN;
    logic [FIELD_W-1:0]    s_pin_levels = '1;
    logic [FIELD_W-1:0]    s_read_short_mask = '0;
    logic [FIELD_W-1:0]    s_read_long_mask = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b1;
    logic [FIELD_W-1:0]    m_short_flags;
    logic [FIELD_W-1:0]    m_long_flags;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state
    logic [TICK_W-1:0]  dbn_cfg = DEBOUNCE_RESET;
    logic [TICK_W-1:0]  lng_cfg = LONG_RESET;
    logic               scan_started = 1'b0;
    btn_phase_t         btn_phase [NUM_BTN];
    logic [TICK_W-1:0]  btn_ticks [NUM_BTN];
    logic [FIELD_W-1:0] short_pend = '0;
    logic [FIELD_W-1:0] long_pend = '0;

    // press pattern generator
    logic               hold_pressed [NUM_BTN];
    int                 hold_left [NUM_BTN];

    flags_t flags_due[$];
    logic   idle_on = 1'b0;
    int     stall_left = 0;
    int     stuck_cycles = 0;
    int     err_count = 0;
    int     words_sent = 0;
    int     words_checked = 0;
    int     short_seen = 0;
    int     long_seen = 0;

    button_short_long_press_detector_unit uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_pin_levels      (s_pin_levels),
        .s_read_short_mask (s_read_short_mask),
        .s_read_long_mask  (s_read_long_mask),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_short_flags     (m_short_flags),
        .m_long_flags      (m_long_flags),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic logic timer_expired(input int b, input logic [TICK_W-1:0] limit);
        if (btn_ticks[b] != '1) btn_ticks[b] = btn_ticks[b] + 1'b1;
        if (btn_ticks[b] >= limit) begin
            btn_ticks[b] = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic flags_t press_predict(input logic kind, input logic [FIELD_W-1:0] pins,
                                             input logic [FIELD_W-1:0] smask,
                                             input logic [FIELD_W-1:0] lmask);
        flags_t res;
        logic   pressed;
        if (kind == KIND_READ) begin
            res.short_f = short_pend & smask;
            res.long_f  = long_pend & lmask;
            short_pend &= ~smask;
            long_pend  &= ~lmask;
            return res;
        end
        if (!scan_started) begin
            scan_started = 1'b1;
        end else begin
            for (int b = 0; b < NUM_BTN; b++) begin
                pressed = !pins[b];
                case (btn_phase[b])
                    PH_IDLE: begin
                        if (pressed) begin
                            btn_ticks[b] = '0;
                            btn_phase[b] = PH_DEBOUNCE;
                        end
                    end
                    PH_DEBOUNCE: begin
                        if (!pressed) btn_phase[b] = PH_IDLE;
                        else if (timer_expired(b, dbn_cfg)) btn_phase[b] = PH_SHORT;
                    end
                    PH_SHORT: begin
                        if (!pressed) begin
                            short_pend[b] = 1'b1;
                            btn_phase[b] = PH_IDLE;
                        end else if (timer_expired(b, lng_cfg)) begin
                            btn_phase[b] = PH_LONG;
                            long_pend[b] = 1'b1;
                        end
                    end
                    default: begin
                        if (!pressed) btn_phase[b] = PH_IDLE;
                    end
                endcase
            end
        end
        res.short_f = short_pend;
        res.long_f  = long_pend;
        return res;
    endfunction

    // well-formed presses: release gaps, bounces, short holds and long holds
    function automatic logic [FIELD_W-1:0] next_pins();
        logic [FIELD_W-1:0] pins;
        int                 span;
        pins = '1;
        span = int'(dbn_cfg) + int'(lng_cfg);
        for (int b = 0; b < NUM_BTN; b++) begin
            if (hold_left[b] == 0) begin
                hold_pressed[b] = !hold_pressed[b];
                if (!hold_pressed[b]) begin
                    hold_left[b] = $urandom_range(1, 4);
                end else begin
                    case ($urandom_range(0, 2))
                        0: hold_left[b] = $urandom_range(1, int'(dbn_cfg) + 1);
                        1: hold_left[b] = $urandom_range(int'(dbn_cfg) + 2, span + 1);
                        default: hold_left[b] = $urandom_range(span + 2, span + 6);
                    endcase
                end
            end
            hold_left[b]--;
            pins[b] = !hold_pressed[b];
        end
        return pins;
    endfunction

    task automatic send_word(input logic kind, input logic [FIELD_W-1:0] pins,
                             input logic [FIELD_W-1:0] smask, input logic [FIELD_W-1:0] lmask);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_kind            <= kind;
        s_pin_levels      <= pins;
        s_read_short_mask <= smask;
        s_read_long_mask  <= lmask;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        flags_due.push_back(press_predict(kind, pins, smask, lmask));
        words_sent++;
    endtask

    task automatic scan(input logic [FIELD_W-1:0] pins);
        send_word(KIND_SCAN, pins, FIELD_W'($urandom), FIELD_W'($urandom));
    endtask

    task automatic read_flags(input logic [FIELD_W-1:0] smask, input logic [FIELD_W-1:0] lmask);
        send_word(KIND_READ, FIELD_W'($urandom), smask, lmask);
    endtask

    task automatic drain_words();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (flags_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [TICK_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {$urandom} & ~CFG_DATA_W'({TICK_W{1'b1}}) | CFG_DATA_W'(val);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == REG_DEBOUNCE_SCANS) dbn_cfg = val;
        else lng_cfg = val;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_timing(input logic [TICK_W-1:0] dbn, input logic [TICK_W-1:0] lng);
        drain_words();
        write_reg(REG_DEBOUNCE_SCANS, dbn);
        write_reg(REG_LONG_SCANS, lng);
    endtask

    // reads before the first scan, the start-up scan, a short press at reset timing
    task automatic test_power_up();
        read_flags(2'b11, 2'b11);
        scan(2'b00);
        repeat (6) scan(2'b10);
        scan(2'b11);
        read_flags(2'b01, 2'b11);
    endtask

    // bounce, short press, long press with silent release, partial reads
    task automatic test_press_timing();
        set_timing(8'd1, 8'd2);
        scan(2'b10);
        scan(2'b11);
        scan(2'b10);
        scan(2'b10);
        scan(2'b11);
        repeat (5) scan(2'b01);
        scan(2'b11);
        read_flags(2'b01, 2'b00);
        read_flags(2'b11, 2'b10);
        read_flags(2'b11, 2'b11);
    endtask

    // zero in both registers acts as one
    task automatic test_register_zero();
        set_timing(8'd0, 8'd0);
        repeat (3) scan(2'b00);
        scan(2'b11);
        read_flags(2'b11, 2'b11);
    endtask

    // largest timing on button 0 while button 1 toggles at random
    task automatic test_extreme_hold();
        set_timing(8'hFF, 8'hFF);
        idle_on = 1'b1;
        for (int i = 0; i < 516; i++) begin
            if ($urandom_range(0, 15) == 0) read_flags(FIELD_W'($urandom), FIELD_W'($urandom));
            else scan({1'($urandom), 1'b0});
        end
        scan(2'b11);
        read_flags(2'b11, 2'b11);
    endtask

    task automatic test_random_presses();
        for (int seg = 0; seg < 6; seg++) begin
            set_timing(TICK_W'($urandom_range(0, 6)), TICK_W'($urandom_range(0, 10)));
            idle_on = (seg < 5) && (seg != 2);
            for (int b = 0; b < NUM_BTN; b++) begin
                hold_pressed[b] = 1'b1;
                hold_left[b]    = 0;
            end
            for (int i = 0; i < 90; i++) begin
                if (i == 45) drain_words();
                case ($urandom_range(0, 15))
                    0, 1: read_flags(FIELD_W'($urandom), FIELD_W'($urandom));
                    2: scan(FIELD_W'($urandom));
                    default: scan(next_pins());
                endcase
            end
        end
        idle_on = 1'b0;
    endtask

    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 9);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        flags_t want;
        if (aresetn && m_valid && m_ready) begin
            if (flags_due.size() == 0) begin
                err_count++;
                $display("%0t: unexpected word short=%b long=%b",
                         $time, m_short_flags, m_long_flags);
            end else begin
                want = flags_due.pop_front();
                words_checked++;
                if (m_short_flags != want.short_f) begin
                    err_count++;
                    $display("%0t: short_flags expected %b actual %b",
                             $time, want.short_f, m_short_flags);
                end
                if (m_long_flags != want.long_f) begin
                    err_count++;
                    $display("%0t: long_flags expected %b actual %b",
                             $time, want.long_f, m_long_flags);
                end
                if (want.short_f != 0) short_seen++;
                if (want.long_f != 0) long_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) stuck_cycles <= 0;
        else stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d words outstanding", $time, flags_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        for (int b = 0; b < NUM_BTN; b++) begin
            btn_phase[b]    = PH_IDLE;
            btn_ticks[b]    = '0;
            hold_pressed[b] = 1'b1;
            hold_left[b]    = 0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_power_up();
        test_press_timing();
        test_register_zero();
        test_extreme_hold();
        test_random_presses();
        drain_words();

        $display("%0d words sent, %0d results checked", words_sent, words_checked);
        $display("results with short flags: %0d, with long flags: %0d", short_seen, long_seen);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
